// ===== sv/assert_macros.svh =====
// assertion macros for the rtl top level
// no dependencies; the checks compile away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/rht_pkg.sv =====
// shared constants and types of the region handle table
// no dependencies
package rht_pkg;

  parameter int TABLE_ENTRIES_DEF = 16;
  parameter int ADDR_BITS_DEF     = 32;
  parameter int HANDLE_BITS_DEF   = 16;

  localparam logic [2:0] CMD_GET     = 3'd0;
  localparam logic [2:0] CMD_CREATE  = 3'd1;
  localparam logic [2:0] CMD_DERIVE  = 3'd2;
  localparam logic [2:0] CMD_MERGE   = 3'd3;
  localparam logic [2:0] CMD_DESTROY = 3'd4;

  // strobes from the sequencer to the entry store
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } st_ctl_t;

endpackage

// ===== sv/memory_region_handle_table.sv =====
// top level of the memory region handle table
// depends on rht_pkg, rht_alu, rht_store, rht_seq and assert_macros.svh
//
//   channel   handshake          payload
//   command   start / busy       cmd, handle_a, handle_b, base, length
//   result    done (one cycle)   status, handle_out, base_out, length_out
//
// a command reads the table one entry per cycle over the single memory read port
// after its start beat, then takes up to six steps on the adder before its done beat.
// busy stays high until the cycle that carries done; start is taken in that cycle.
// reset empties the table at once through the valid flops and sets the next handle to 1.
// done flags the result for one cycle only; the receiver must take it then.
`include "assert_macros.svh"
module memory_region_handle_table #(
  parameter int TABLE_ENTRIES = rht_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_BITS     = rht_pkg::ADDR_BITS_DEF,
  parameter int HANDLE_BITS   = rht_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  cmd,
  input  logic [15:0] handle_a,
  input  logic [15:0] handle_b,
  input  logic [31:0] base,
  input  logic [31:0] length,
  output logic        busy,
  output logic        done,
  output logic        status,
  output logic [15:0] handle_out,
  output logic [31:0] base_out,
  output logic [31:0] length_out
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int HW = (HANDLE_BITS > 16) ? HANDLE_BITS : 16;
  localparam int AW = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  logic [HW-1:0]          ha_w, hb_w, hout_w;
  logic [AW-1:0]          base_w, len_w, bout_w, lout_w;
  logic [HANDLE_BITS-1:0] ha, hb, h_res, wr_handle, q_handle;
  logic [ADDR_BITS-1:0]   base_c, len_c, nb_res, nl_res;
  logic [ADDR_BITS-1:0]   wr_base, wr_len, q_base, q_len;
  logic [ADDR_BITS-1:0]   alu_x, alu_y, alu_sum;
  logic                   alu_sub, alu_carry, q_valid;
  logic [IW-1:0]          rd_addr, wr_addr;
  rht_pkg::st_ctl_t       st_ctl;

  // fit port widths to the configured handle and address widths
  assign ha_w   = HW'(handle_a);
  assign hb_w   = HW'(handle_b);
  assign ha     = ha_w[HANDLE_BITS-1:0];
  assign hb     = hb_w[HANDLE_BITS-1:0];
  assign base_w = AW'(base);
  assign len_w  = AW'(length);
  assign base_c = base_w[ADDR_BITS-1:0];
  assign len_c  = len_w[ADDR_BITS-1:0];

  assign hout_w     = HW'(h_res);
  assign bout_w     = AW'(nb_res);
  assign lout_w     = AW'(nl_res);
  assign handle_out = hout_w[15:0];
  assign base_out   = bout_w[31:0];
  assign length_out = lout_w[31:0];

  rht_alu #(.W(ADDR_BITS)) u_alu (
    .x     (alu_x),
    .y     (alu_y),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  rht_store #(
    .N  (TABLE_ENTRIES),
    .AB (ADDR_BITS),
    .HB (HANDLE_BITS),
    .IW (IW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (st_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_handle (wr_handle),
    .wr_base   (wr_base),
    .wr_len    (wr_len),
    .q_valid   (q_valid),
    .q_handle  (q_handle),
    .q_base    (q_base),
    .q_len     (q_len)
  );

  rht_seq #(
    .N  (TABLE_ENTRIES),
    .AB (ADDR_BITS),
    .HB (HANDLE_BITS),
    .IW (IW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .ha        (ha),
    .hb        (hb),
    .base      (base_c),
    .len       (len_c),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .h_res     (h_res),
    .nb_res    (nb_res),
    .nl_res    (nl_res),
    .st_ctl    (st_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_handle (wr_handle),
    .wr_base   (wr_base),
    .wr_len    (wr_len),
    .q_valid   (q_valid),
    .q_handle  (q_handle),
    .q_base    (q_base),
    .q_len     (q_len),
    .alu_x     (alu_x),
    .alu_y     (alu_y),
    .alu_sub   (alu_sub),
    .alu_sum   (alu_sum),
    .alu_carry (alu_carry)
  );

  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy && !done)
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `ASSERT_IMPLY(a_fail_zero, clk, rst, done && status, {handle_out, base_out, length_out} == '0)

endmodule

// ===== sv/rht_alu.sv =====
// shared add/subtract unit with carry out
// no dependencies
module rht_alu #(
  parameter int W = 32
) (
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W-1:0] y_op;

  // on subtract, carry set means x >= y
  always_comb begin
    y_op = sub ? ~y : y;
    {carry, sum} = {1'b0, x} + {1'b0, y_op} + {{W{1'b0}}, sub};
  end

endmodule

// ===== sv/rht_store.sv =====
// entry store: handle, base and length memory plus valid bits
// depends on rht_pkg
module rht_store #(
  parameter int N  = rht_pkg::TABLE_ENTRIES_DEF,
  parameter int AB = rht_pkg::ADDR_BITS_DEF,
  parameter int HB = rht_pkg::HANDLE_BITS_DEF,
  parameter int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  rht_pkg::st_ctl_t ctl,
  input  logic [IW-1:0]    rd_addr,
  input  logic [IW-1:0]    wr_addr,
  input  logic [HB-1:0]    wr_handle,
  input  logic [AB-1:0]    wr_base,
  input  logic [AB-1:0]    wr_len,
  output logic             q_valid,
  output logic [HB-1:0]    q_handle,
  output logic [AB-1:0]    q_base,
  output logic [AB-1:0]    q_len
);

  localparam int DW = HB + 2 * AB;

  logic [DW-1:0] mem [N];
  logic [DW-1:0] q_data;
  logic [N-1:0]  valid;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= {wr_handle, wr_base, wr_len};
    end
    if (ctl.rd) begin
      q_data  <= mem[rd_addr];
      q_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.wr) begin
      valid[wr_addr] <= 1'b1;
    end else if (ctl.clr) begin
      valid[wr_addr] <= 1'b0;
    end
  end

  assign q_handle = q_data[DW-1 -: HB];
  assign q_base   = q_data[2*AB-1 -: AB];
  assign q_len    = q_data[AB-1:0];

endmodule

// ===== sv/rht_seq.sv =====
// command sequencer: entry scan, arithmetic steps on the shared unit, insert
// depends on rht_pkg; drives rht_store and rht_alu
module rht_seq #(
  parameter int N  = rht_pkg::TABLE_ENTRIES_DEF,
  parameter int AB = rht_pkg::ADDR_BITS_DEF,
  parameter int HB = rht_pkg::HANDLE_BITS_DEF,
  parameter int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       cmd,
  input  logic [HB-1:0]    ha,
  input  logic [HB-1:0]    hb,
  input  logic [AB-1:0]    base,
  input  logic [AB-1:0]    len,
  output logic             busy,
  output logic             done,
  output logic             status,
  output logic [HB-1:0]    h_res,
  output logic [AB-1:0]    nb_res,
  output logic [AB-1:0]    nl_res,
  output rht_pkg::st_ctl_t st_ctl,
  output logic [IW-1:0]    rd_addr,
  output logic [IW-1:0]    wr_addr,
  output logic [HB-1:0]    wr_handle,
  output logic [AB-1:0]    wr_base,
  output logic [AB-1:0]    wr_len,
  input  logic             q_valid,
  input  logic [HB-1:0]    q_handle,
  input  logic [AB-1:0]    q_base,
  input  logic [AB-1:0]    q_len,
  output logic [AB-1:0]    alu_x,
  output logic [AB-1:0]    alu_y,
  output logic             alu_sub,
  input  logic [AB-1:0]    alu_sum,
  input  logic             alu_carry
);

  localparam int CW = $clog2(N + 1);
  localparam logic [CW-1:0] N_C = CW'(N);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_CALC = 5'b00100,
    S_INS  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t        state;
  logic [2:0]    step;
  logic [CW-1:0] cnt;
  logic          pv;
  logic [IW-1:0] pidx;
  logic [2:0]    cmd_r;
  logic [HB-1:0] ha_r, hb_r;
  logic [AB-1:0] base_r, len_r;
  logic          found_a, found_b, free_found;
  logic [IW-1:0] a_idx, free_idx;
  logic [AB-1:0] a_base, a_len, b_base, b_len;
  logic [AB-1:0] t0, t1;
  logic          swap;
  logic          res_ok;
  logic [AB-1:0] nb, nl;
  logic [HB-1:0] h_r;
  logic [HB-1:0] next_handle;
  logic [AB-1:0] lo_base, hi_base, lo_end, hi_end;
  logic          can_ins;

  assign busy = (state != S_IDLE);

  assign lo_base = swap ? b_base : a_base;
  assign hi_base = swap ? a_base : b_base;
  assign lo_end  = swap ? t1 : t0;
  assign hi_end  = swap ? t0 : t1;

  assign can_ins = (next_handle != '0) && free_found;

  assign st_ctl.rd  = (state == S_SCAN) && (cnt < N_C);
  assign st_ctl.wr  = (state == S_INS) && can_ins;
  assign st_ctl.clr = (state == S_CALC) && (cmd_r == rht_pkg::CMD_DESTROY) && found_a;

  assign rd_addr   = cnt[IW-1:0];
  assign wr_addr   = (cmd_r == rht_pkg::CMD_DESTROY) ? a_idx : free_idx;
  assign wr_handle = next_handle;
  assign wr_base   = nb;
  assign wr_len    = nl;

  // operand select for the shared unit, by command and step
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    case (cmd_r)
      rht_pkg::CMD_CREATE: begin
        alu_x = base_r;
        alu_y = len_r;
      end
      rht_pkg::CMD_DERIVE: begin
        case (step)
          3'd0: begin alu_x = base_r; alu_y = len_r; end
          3'd1: begin alu_x = a_base; alu_y = a_len; end
          3'd2: begin alu_x = base_r; alu_y = a_base; alu_sub = 1'b1; end
          3'd3: begin alu_x = t1; alu_y = t0; alu_sub = 1'b1; end
          default: ;
        endcase
      end
      rht_pkg::CMD_MERGE: begin
        case (step)
          3'd0: begin alu_x = a_base; alu_y = a_len; end
          3'd1: begin alu_x = b_base; alu_y = b_len; end
          3'd2: begin
            alu_sub = 1'b1;
            if (a_len == '0 && b_len == '0) begin
              alu_x = a_base;
              alu_y = b_base;
            end else begin
              alu_x = b_base;
              alu_y = a_base;
            end
          end
          3'd3: begin alu_x = lo_end; alu_y = hi_base; alu_sub = 1'b1; end
          3'd4: begin alu_x = lo_end; alu_y = hi_end; alu_sub = 1'b1; end
          3'd5: begin alu_x = t0; alu_y = lo_base; alu_sub = 1'b1; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      pv          <= 1'b0;
      next_handle <= HB'(1);
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r      <= cmd;
            ha_r       <= ha;
            hb_r       <= hb;
            base_r     <= base;
            len_r      <= len;
            cnt        <= '0;
            pv         <= 1'b0;
            step       <= 3'd0;
            found_a    <= 1'b0;
            found_b    <= 1'b0;
            free_found <= 1'b0;
            res_ok     <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read data of entry pidx arrives in the cycle after its address
          pv   <= (cnt < N_C);
          pidx <= cnt[IW-1:0];
          if (cnt < N_C) begin
            cnt <= cnt + CW'(1);
          end
          if (pv) begin
            if (q_valid && ha_r != '0 && q_handle == ha_r) begin
              found_a <= 1'b1;
              a_idx   <= pidx;
              a_base  <= q_base;
              a_len   <= q_len;
            end
            if (q_valid && hb_r != '0 && q_handle == hb_r) begin
              found_b <= 1'b1;
              b_base  <= q_base;
              b_len   <= q_len;
            end
            if (!q_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pidx;
            end
          end
          if (cnt == N_C && !pv) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          step <= step + 3'd1;
          case (cmd_r)
            rht_pkg::CMD_GET: begin
              res_ok <= found_a;
              nb     <= a_base;
              nl     <= a_len;
              h_r    <= ha_r;
              state  <= S_FIN;
            end
            rht_pkg::CMD_DESTROY: begin
              res_ok <= found_a;
              nb     <= '0;
              nl     <= '0;
              h_r    <= '0;
              state  <= S_FIN;
            end
            rht_pkg::CMD_CREATE: begin
              if (alu_carry) begin
                state <= S_FIN;
              end else begin
                nb    <= base_r;
                nl    <= len_r;
                state <= S_INS;
              end
            end
            rht_pkg::CMD_DERIVE: begin
              case (step)
                3'd0: begin
                  if (!found_a || alu_carry) state <= S_FIN;
                  else t0 <= alu_sum;
                end
                3'd1: begin
                  if (alu_carry) state <= S_FIN;
                  else t1 <= alu_sum;
                end
                3'd2: begin
                  if (!alu_carry) state <= S_FIN;
                end
                3'd3: begin
                  if (!alu_carry) begin
                    state <= S_FIN;
                  end else begin
                    nb    <= base_r;
                    nl    <= len_r;
                    state <= S_INS;
                  end
                end
                default: state <= S_FIN;
              endcase
            end
            rht_pkg::CMD_MERGE: begin
              case (step)
                3'd0: begin
                  if (!found_a || !found_b || alu_carry) state <= S_FIN;
                  else t0 <= alu_sum;
                end
                3'd1: begin
                  if (alu_carry) state <= S_FIN;
                  else t1 <= alu_sum;
                end
                3'd2: begin
                  if (a_len == '0 && b_len == '0) begin
                    nb    <= alu_carry ? b_base : a_base;
                    nl    <= '0;
                    state <= S_INS;
                  end else if (a_len == '0) begin
                    nb    <= b_base;
                    nl    <= b_len;
                    state <= S_INS;
                  end else if (b_len == '0) begin
                    nb    <= a_base;
                    nl    <= a_len;
                    state <= S_INS;
                  end else begin
                    // b below a: b becomes the lower region
                    swap <= !alu_carry;
                  end
                end
                3'd3: begin
                  if (!alu_carry) state <= S_FIN;
                end
                3'd4: begin
                  t0 <= alu_carry ? lo_end : hi_end;
                end
                3'd5: begin
                  nb    <= lo_base;
                  nl    <= alu_sum;
                  state <= S_INS;
                end
                default: state <= S_FIN;
              endcase
            end
            default: state <= S_FIN;
          endcase
        end
        S_INS: begin
          if (can_ins) begin
            res_ok      <= 1'b1;
            h_r         <= next_handle;
            next_handle <= next_handle + HB'(1);
          end else begin
            res_ok <= 1'b0;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          done   <= 1'b1;
          status <= !res_ok;
          h_res  <= res_ok ? h_r : '0;
          nb_res <= res_ok ? nb : '0;
          nl_res <= res_ok ? nl : '0;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/region_table_checker.sv =====
// result checker for the memory region handle table: keeps its own copy of the
// table, predicts one result per command beat and compares it with the result beat
// depends on rht_pkg
module region_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  cmd,
  input  logic [15:0] handle_a,
  input  logic [15:0] handle_b,
  input  logic [31:0] base,
  input  logic [31:0] length,
  input  logic        done,
  input  logic        status,
  input  logic [15:0] handle_out,
  input  logic [31:0] base_out,
  input  logic [31:0] length_out,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = rht_pkg::TABLE_ENTRIES_DEF;
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic        status;
    logic [15:0] hdl;
    logic [31:0] bas;
    logic [31:0] len;
  } region_result_t;

  logic        slot_valid  [SLOTS];
  logic [15:0] slot_handle [SLOTS];
  logic [31:0] slot_base   [SLOTS];
  logic [31:0] slot_length [SLOTS];
  logic [15:0] next_handle;

  region_result_t pending_results [$];

  task automatic report(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  function automatic int find_slot(input logic [15:0] h);
    if (h == 16'd0) return -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_handle[i] == h) return i;
    return -1;
  endfunction

  function automatic region_result_t apply_command(input logic [2:0] c,
                                                   input logic [15:0] ha,
                                                   input logic [15:0] hb,
                                                   input logic [31:0] b,
                                                   input logic [31:0] l);
    region_result_t r;
    int ia, ib, lo, hi;
    logic [32:0] new_end, src_end, a_end, b_end, lo_end, hi_end;
    logic [31:0] nb, nl;
    logic ok, add;
    r = '0;
    ok = 1'b0;
    add = 1'b0;
    nb = '0;
    nl = '0;
    new_end = {1'b0, b} + {1'b0, l};
    case (c)
      rht_pkg::CMD_GET: begin
        ia = find_slot(ha);
        if (ia >= 0) begin
          ok = 1'b1;
          r.hdl = slot_handle[ia];
          nb = slot_base[ia];
          nl = slot_length[ia];
        end
      end
      rht_pkg::CMD_CREATE: begin
        if (!new_end[32]) begin
          nb = b;
          nl = l;
          add = 1'b1;
        end
      end
      rht_pkg::CMD_DERIVE: begin
        ia = find_slot(ha);
        if (ia >= 0) begin
          src_end = {1'b0, slot_base[ia]} + {1'b0, slot_length[ia]};
          if (!new_end[32] && !src_end[32] && b >= slot_base[ia] && new_end <= src_end) begin
            nb = b;
            nl = l;
            add = 1'b1;
          end
        end
      end
      rht_pkg::CMD_MERGE: begin
        ia = find_slot(ha);
        ib = find_slot(hb);
        if (ia >= 0 && ib >= 0) begin
          a_end = {1'b0, slot_base[ia]} + {1'b0, slot_length[ia]};
          b_end = {1'b0, slot_base[ib]} + {1'b0, slot_length[ib]};
          if (!a_end[32] && !b_end[32]) begin
            if (slot_length[ia] == 0 && slot_length[ib] == 0) begin
              nb = (slot_base[ia] < slot_base[ib]) ? slot_base[ia] : slot_base[ib];
              nl = '0;
              add = 1'b1;
            end else if (slot_length[ia] == 0) begin
              nb = slot_base[ib];
              nl = slot_length[ib];
              add = 1'b1;
            end else if (slot_length[ib] == 0) begin
              nb = slot_base[ia];
              nl = slot_length[ia];
              add = 1'b1;
            end else begin
              // on equal bases a is taken as the lower region
              lo = ia;
              hi = ib;
              lo_end = a_end;
              hi_end = b_end;
              if (slot_base[ia] > slot_base[ib]) begin
                lo = ib;
                hi = ia;
                lo_end = b_end;
                hi_end = a_end;
              end
              if ({1'b0, slot_base[hi]} <= lo_end) begin
                nb = slot_base[lo];
                nl = 32'((lo_end > hi_end ? lo_end : hi_end) - {1'b0, nb});
                add = 1'b1;
              end
            end
          end
        end
      end
      rht_pkg::CMD_DESTROY: begin
        ia = find_slot(ha);
        if (ia >= 0) begin
          slot_valid[ia] = 1'b0;
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    // a wrapped handle counter blocks every insert until reset
    if (add && next_handle != 16'd0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_valid[i] && !ok) begin
          slot_valid[i] = 1'b1;
          slot_handle[i] = next_handle;
          slot_base[i] = nb;
          slot_length[i] = nl;
          r.hdl = next_handle;
          next_handle = next_handle + 16'd1;
          ok = 1'b1;
        end
      end
    end
    if (ok) begin
      r.status = ST_OK;
      r.bas = nb;
      r.len = nl;
    end else begin
      r = '0;
      r.status = ST_FAIL;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    region_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      next_handle = 16'd1;
      pending_results.delete();
    end else begin
      // the result beat of the previous command can share an edge with a new command beat
      if (done) begin
        if (pending_results.size() == 0) begin
          report("result beat with no command outstanding");
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report($sformatf("status got %0b want %0b", status, want.status));
          if (handle_out !== want.hdl)
            report($sformatf("handle_out got %h want %h", handle_out, want.hdl));
          if (base_out !== want.bas)
            report($sformatf("base_out got %h want %h", base_out, want.bas));
          if (length_out !== want.len)
            report($sformatf("length_out got %h want %h", length_out, want.len));
        end
      end
      if (start && !busy)
        pending_results.push_back(apply_command(cmd, handle_a, handle_b, base, length));
    end
    pending = pending_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
// top of the region handle table bench: clock, reset, command stimulus and verdict
// depends on rht_pkg, memory_region_handle_table and region_table_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 1520;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LIVE_KEEP      = 32;

  typedef struct packed {
    logic [15:0] hdl;
    logic [31:0] bas;
    logic [31:0] len;
  } live_region_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  logic [2:0]  cmd        = '0;
  logic [15:0] handle_a   = '0;
  logic [15:0] handle_b   = '0;
  logic [31:0] base       = '0;
  logic [31:0] length     = '0;
  logic        busy;
  logic        done;
  logic        status;
  logic [15:0] handle_out;
  logic [31:0] base_out;
  logic [31:0] length_out;
  int          fail_count;
  int          pending;
  int          issued = 0;
  int          idle_cycles = 0;

  // regions believed live, learned from result beats; used to aim handles
  live_region_t live_regions [$];
  logic [2:0]   sent_cmds [$];

  memory_region_handle_table DUT (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .handle_a(handle_a),
    .handle_b(handle_b), .base(base), .length(length), .busy(busy), .done(done),
    .status(status), .handle_out(handle_out), .base_out(base_out), .length_out(length_out)
  );

  region_table_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .handle_a(handle_a),
    .handle_b(handle_b), .base(base), .length(length), .done(done), .status(status),
    .handle_out(handle_out), .base_out(base_out), .length_out(length_out),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin : learn
    logic [2:0] done_cmd;
    if (!rst && done && sent_cmds.size() > 0) begin
      done_cmd = sent_cmds.pop_front();
      if ((done_cmd == rht_pkg::CMD_CREATE || done_cmd == rht_pkg::CMD_DERIVE ||
           done_cmd == rht_pkg::CMD_MERGE) && handle_out != 16'd0) begin
        live_regions.push_back('{handle_out, base_out, length_out});
        if (live_regions.size() > LIVE_KEEP) void'(live_regions.pop_front());
      end
    end
  end

  // one command beat, after a random gap except in the stretches without idling
  task automatic issue(input logic [2:0] c, input logic [15:0] ha, input logic [15:0] hb,
                       input logic [31:0] b, input logic [31:0] l);
    int n, r;
    n = 0;
    if (((issued / 64) % 4) != 3) begin
      r = $urandom_range(0, 99);
      if (r >= 90) n = $urandom_range(8, 40);
      else if (r >= 50) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    handle_a <= ha;
    handle_b <= hb;
    base <= b;
    length <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_cmds.push_back(c);
    issued++;
  endtask

  function automatic logic [15:0] pick_handle();
    int r;
    live_region_t pick;
    r = $urandom_range(0, 99);
    if (live_regions.size() == 0 || r < 8) return 16'($urandom);
    if (r < 12) return 16'd0;
    pick = live_regions[$urandom_range(0, live_regions.size() - 1)];
    if (r < 16) return pick.hdl + 16'd1;
    return pick.hdl;
  endfunction

  task automatic create_item();
    int r;
    logic [31:0] b, l;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // small regions packed into a few windows so that merges often touch or overlap
      case ($urandom_range(0, 2))
        0: b = 32'h0000_0000;
        1: b = 32'h8000_0000;
        default: b = 32'hFFFF_F800;
      endcase
      b = b + $urandom_range(0, 'h300);
      l = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 'h200));
    end else if (r < 65) begin
      b = 32'hFFFF_FFFF - $urandom_range(0, 'h400);
      l = $urandom_range(0, 'h800);
    end else if (r < 75) begin
      b = $urandom;
      case ($urandom_range(0, 2))
        0: l = 32'd0;
        1: l = 32'd1;
        default: l = 32'hFFFF_FFFF;
      endcase
    end else begin
      b = $urandom;
      l = $urandom;
    end
    issue(rht_pkg::CMD_CREATE, 16'($urandom), 16'($urandom), b, l);
  endtask

  task automatic derive_item();
    live_region_t src;
    longint unsigned lo, hi, nb, nl;
    int r;
    if (live_regions.size() == 0 || $urandom_range(0, 99) < 15) begin
      issue(rht_pkg::CMD_DERIVE, pick_handle(), 16'($urandom), $urandom, $urandom);
    end else begin
      src = live_regions[$urandom_range(0, live_regions.size() - 1)];
      lo = src.bas;
      hi = lo + src.len;
      nb = lo + (longint'($urandom) % (longint'(src.len) + 1));
      nl = longint'($urandom) % (hi - nb + 1);
      // now and then push the sub-range one byte outside its source
      r = $urandom_range(0, 9);
      if (r == 0) nb = nb - 1;
      else if (r == 1) nl = nl + 1;
      issue(rht_pkg::CMD_DERIVE, src.hdl, 16'($urandom), nb[31:0], nl[31:0]);
    end
  endtask

  task automatic random_item(input bit filling);
    int r;
    logic [15:0] h;
    r = $urandom_range(0, 99);
    if (r < (filling ? 30 : 15)) begin
      create_item();
    end else if (r < (filling ? 50 : 27)) begin
      derive_item();
    end else if (r < (filling ? 70 : 39)) begin
      h = pick_handle();
      issue(rht_pkg::CMD_MERGE, h, ($urandom_range(0, 4) == 0) ? h : pick_handle(),
            $urandom, $urandom);
    end else if (r < (filling ? 87 : 57)) begin
      issue(rht_pkg::CMD_GET, pick_handle(), 16'($urandom), $urandom, $urandom);
    end else if (r < 97) begin
      h = pick_handle();
      for (int i = live_regions.size() - 1; i >= 0; i--)
        if (live_regions[i].hdl == h) live_regions.delete(i);
      issue(rht_pkg::CMD_DESTROY, h, 16'($urandom), $urandom, $urandom);
    end else begin
      issue(3'($urandom_range(int'(rht_pkg::CMD_DESTROY) + 1, 7)), pick_handle(),
            pick_handle(), $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // handles count up from 1 on a fresh table
    issue(rht_pkg::CMD_GET,     16'd0, 16'd0, 32'd0, 32'd0);
    issue(rht_pkg::CMD_CREATE,  16'd0, 16'd0, 32'h0000_0000, 32'h0000_0000);
    issue(rht_pkg::CMD_CREATE,  16'd0, 16'd0, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(rht_pkg::CMD_CREATE,  16'd0, 16'd0, 32'hFFFF_FFFF, 32'h0000_0001);
    issue(rht_pkg::CMD_CREATE,  16'd0, 16'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(rht_pkg::CMD_CREATE,  16'd0, 16'd0, 32'h0000_1000, 32'h0000_0100);
    issue(rht_pkg::CMD_CREATE,  16'd0, 16'd0, 32'h0000_1080, 32'h0000_0100);
    issue(rht_pkg::CMD_CREATE,  16'd0, 16'd0, 32'h0000_1180, 32'h0000_0080);
    // overlapping, touching, gapped, both empty, one empty, self
    issue(rht_pkg::CMD_MERGE,   16'd4, 16'd5, 32'd0, 32'd0);
    issue(rht_pkg::CMD_MERGE,   16'd5, 16'd6, 32'd0, 32'd0);
    issue(rht_pkg::CMD_MERGE,   16'd4, 16'd6, 32'd0, 32'd0);
    issue(rht_pkg::CMD_MERGE,   16'd1, 16'd2, 32'd0, 32'd0);
    issue(rht_pkg::CMD_MERGE,   16'd1, 16'd4, 32'd0, 32'd0);
    issue(rht_pkg::CMD_MERGE,   16'd4, 16'd4, 32'd0, 32'd0);
    issue(rht_pkg::CMD_DERIVE,  16'd4, 16'd0, 32'h0000_1000, 32'h0000_0100);
    issue(rht_pkg::CMD_DERIVE,  16'd4, 16'd0, 32'h0000_0FFF, 32'h0000_0001);
    issue(rht_pkg::CMD_DERIVE,  16'd4, 16'd0, 32'h0000_1001, 32'h0000_0100);
    issue(rht_pkg::CMD_DERIVE,  16'd3, 16'd0, 32'hFFFF_FFFF, 32'h0000_0001);
    issue(rht_pkg::CMD_DESTROY, 16'd4, 16'd0, 32'd0, 32'd0);
    issue(rht_pkg::CMD_DESTROY, 16'd4, 16'd0, 32'd0, 32'd0);
    issue(rht_pkg::CMD_GET,     16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(3'd7,                 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill the table, then one more create and one merge on the full table
    repeat (6) issue(rht_pkg::CMD_CREATE, 16'd0, 16'd0, 32'h0000_2000, 32'h0000_0010);
    issue(rht_pkg::CMD_MERGE,   16'd5, 16'd6, 32'd0, 32'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++)
      random_item(((i / 100) % 2) == 0);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    // a result beat that never came leaves its command outstanding
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
